FILE: hdl/tis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_pkg
// Shared constants and types for the trie insert/search core.
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int NODES     = 1024;
    localparam int ALPHABET  = 26;
    localparam int ID_BITS   = 16;

    localparam int NODE_W    = $clog2(NODES);
    localparam int SYM_W     = $clog2(ALPHABET);
    localparam int CNT_W     = $clog2(NODES + 1);

    localparam int SYMBOL_W  = 5;
    localparam int WORD_ID_W = 16;
    localparam int USED_W    = 11;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef logic [NODE_W-1:0] node_t;

    // One memory row per trie node: child links plus word tag bookkeeping.
    typedef struct packed {
        logic                      tag_valid;
        logic                      has_child;
        logic [ID_BITS-1:0]        tag_id;
        node_t [ALPHABET-1:0]      link;
    } row_t;

    typedef struct packed {
        logic  rd_en;
        node_t rd_addr;
        logic  wr_en;
        node_t wr_addr;
        row_t  wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                req_type;
        logic [SYMBOL_W-1:0] symbol;
        logic                no_symbol;
        logic                last;
    } item_t;

    typedef struct packed {
        logic                 found;
        logic [WORD_ID_W-1:0] word_id;
        logic                 table_full;
        logic                 prefix_free;
        logic [USED_W-1:0]    nodes_used;
    } result_t;

endpackage

FILE: hdl/tis_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_req_if
// Request channel: one letter beat of a word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tis_req_if;

    logic       valid;
    logic       ready;
    logic       req_type;
    logic [4:0] symbol;
    logic       no_symbol;
    logic       last;

    modport source (
        output valid,
        output req_type,
        output symbol,
        output no_symbol,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  symbol,
        input  no_symbol,
        input  last,
        output ready
    );

endinterface

FILE: hdl/tis_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_rsp_if
// Response channel: one result beat per completed word.
// ----------------------------------------------------------------------------
interface tis_rsp_if;

    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] word_id;
    logic        table_full;
    logic        prefix_free;
    logic [10:0] nodes_used;

    modport source (
        output valid,
        output found,
        output word_id,
        output table_full,
        output prefix_free,
        output nodes_used,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  word_id,
        input  table_full,
        input  prefix_free,
        input  nodes_used,
        output ready
    );

endinterface

FILE: hdl/tis_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_node_mem
// Node-row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tis_node_mem (
    input  logic              clk,
    input  tis_pkg::mem_req_t req,
    output tis_pkg::row_t     rd_row
);
    import tis_pkg::*;

    row_t row_mem [NODES];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            row_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= row_mem[req.rd_addr];
        end
    end

    assign rd_row = rd_data_reg;

endmodule

FILE: hdl/tis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_ctrl
// Walk sequencer: reads the cursor row, follows or allocates a child link,
// tags or checks the end node and builds the result beat.
// ----------------------------------------------------------------------------
module tis_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  tis_pkg::item_t     in_item,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_free,
    output logic               res_valid,
    output tis_pkg::result_t   res,
    output tis_pkg::mem_req_t  mem_req,
    input  tis_pkg::row_t      rd_row
);
    import tis_pkg::*;

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_ALLOC = 4'b1000
    } state_t;

    state_t             state_reg,   state_next;
    item_t              item_reg,    item_next;
    node_t              cursor_reg,  cursor_next;
    node_t              alloc_reg,   alloc_next;
    logic               failed_reg,  failed_next;
    logic               stepped_reg, stepped_next;
    logic               prefix_reg,  prefix_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [ID_BITS-1:0] ctr_reg,     ctr_next;

    logic               accept;
    logic               has_letter;
    logic               active;
    logic               is_search;
    logic               room;
    logic [SYM_W-1:0]   sym_idx;
    node_t              link_val;
    node_t              new_node;
    logic               finish;
    logic               fail_now;

    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign accept     = in_valid && in_ready;
    assign has_letter = !item_reg.no_symbol && (32'(item_reg.symbol) < 32'(ALPHABET));
    assign active     = has_letter && !failed_reg && !stepped_reg;
    assign is_search  = (item_reg.req_type == REQ_SEARCH);
    assign room       = (count_reg < CNT_W'(NODES));
    assign sym_idx    = SYM_W'(item_reg.symbol);
    assign link_val   = has_letter ? rd_row.link[sym_idx] : '0;
    assign new_node   = count_reg[NODE_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        cursor_next  = cursor_reg;
        alloc_next   = alloc_reg;
        failed_next  = failed_reg;
        stepped_next = stepped_reg;
        prefix_next  = prefix_reg;
        count_next   = count_reg;
        ctr_next     = ctr_reg;
        mem_req      = '0;
        res_valid    = 1'b0;
        res          = '0;
        finish       = 1'b0;
        fail_now     = failed_reg;

        case (state_reg)
            S_INIT:
            begin
                // root row is the only row not cleared on allocation
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = '0;
                state_next      = S_IDLE;
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    item_next       = in_item;
                    stepped_next    = 1'b0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = cursor_reg;
                    state_next      = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                finish     = item_reg.last;
                if (active)
                begin
                    if (link_val != '0)
                    begin
                        cursor_next = link_val;
                        finish      = 1'b0;
                        if (item_reg.last)
                        begin
                            // fetch the reached node's tag before finishing
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = link_val;
                            stepped_next    = 1'b1;
                            state_next      = S_EXEC;
                        end
                    end
                    else if (is_search || !room)
                    begin
                        fail_now    = 1'b1;
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        finish                   = 1'b0;
                        mem_req.wr_en            = 1'b1;
                        mem_req.wr_addr          = cursor_reg;
                        mem_req.wr_data          = rd_row;
                        mem_req.wr_data.link[sym_idx] = new_node;
                        mem_req.wr_data.has_child = 1'b1;
                        if (rd_row.tag_valid)
                        begin
                            prefix_next = 1'b0;
                        end
                        count_next  = count_reg + 1'b1;
                        cursor_next = new_node;
                        alloc_next  = new_node;
                        state_next  = S_ALLOC;
                    end
                end

                if (finish)
                begin
                    res_valid = 1'b1;
                    if (is_search)
                    begin
                        if (!fail_now && rd_row.tag_valid)
                        begin
                            res.found   = 1'b1;
                            res.word_id = WORD_ID_W'(rd_row.tag_id);
                        end
                    end
                    else if (fail_now)
                    begin
                        res.table_full = 1'b1;
                    end
                    else
                    begin
                        mem_req.wr_en             = 1'b1;
                        mem_req.wr_addr           = cursor_reg;
                        mem_req.wr_data           = rd_row;
                        mem_req.wr_data.tag_valid = 1'b1;
                        mem_req.wr_data.tag_id    = ctr_reg;
                        if (rd_row.has_child)
                        begin
                            prefix_next = 1'b0;
                        end
                        res.found   = 1'b1;
                        res.word_id = WORD_ID_W'(ctr_reg);
                        ctr_next    = ctr_reg + 1'b1;
                    end
                    res.prefix_free = prefix_next;
                    res.nodes_used  = USED_W'(count_next);
                    cursor_next     = '0;
                    failed_next     = 1'b0;
                    stepped_next    = 1'b0;
                end
            end

            S_ALLOC:
            begin
                // clear the fresh row; a final letter tags it in the same write
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = alloc_reg;
                mem_req.wr_data = '0;
                state_next      = S_IDLE;
                if (item_reg.last)
                begin
                    mem_req.wr_data.tag_valid = 1'b1;
                    mem_req.wr_data.tag_id    = ctr_reg;
                    res_valid       = 1'b1;
                    res.found       = 1'b1;
                    res.word_id     = WORD_ID_W'(ctr_reg);
                    res.prefix_free = prefix_reg;
                    res.nodes_used  = USED_W'(count_reg);
                    ctr_next        = ctr_reg + 1'b1;
                    cursor_next     = '0;
                    failed_next     = 1'b0;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            cursor_reg  <= '0;
            failed_reg  <= 1'b0;
            stepped_reg <= 1'b0;
            prefix_reg  <= 1'b1;
            count_reg   <= CNT_W'(1);
            ctr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            failed_reg  <= failed_next;
            stepped_reg <= stepped_next;
            prefix_reg  <= prefix_next;
            count_reg   <= count_next;
            ctr_reg     <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        alloc_reg <= alloc_next;
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("node memory read and write in the same cycle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(NODES)))
        else $error("node count out of range");

    a_cursor_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(cursor_reg) < count_reg)
        else $error("cursor points at an unallocated node");

    a_result_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (cursor_reg == '0) && !failed_reg)
        else $error("walk did not return to root after a result");

endmodule

FILE: hdl/trie_insert_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_insert_search_core
// Trie over a 26-letter alphabet with word insert and search.
// ----------------------------------------------------------------------------
// Words arrive one letter beat at a time on req and are processed one beat
// at a time against a single node-row memory (one row per node, holding all
// child links and the word tag). A letter that follows an existing link, or
// a beat with no letter, is handled by accepting it and reading the cursor
// row, then acting on it. Allocating a node adds a state that clears the
// new row. A final letter that follows an existing link adds a read of the
// reached node's row. The registered read data of the node memory sets
// these steps. After reset the block clears the root row before it takes
// its first beat. A result beat is produced on rsp for every beat marked
// last and is held in an output register; a new beat is taken only while
// that register is empty or being read in the same cycle, so a stalled
// result holds off the next beat.
// ----------------------------------------------------------------------------
module trie_insert_search_core (
    input  logic clk,
    input  logic rst_n,
    tis_req_if.sink   req,
    tis_rsp_if.source rsp
);
    import tis_pkg::*;

    item_t    in_item;
    logic     out_free;
    logic     res_valid;
    result_t  res;
    mem_req_t mem_req;
    row_t     rd_row;

    logic     rsp_valid_reg;
    result_t  rsp_data_reg;

    assign in_item.req_type  = req.req_type;
    assign in_item.symbol    = req.symbol;
    assign in_item.no_symbol = req.no_symbol;
    assign in_item.last      = req.last;

    assign out_free = !rsp_valid_reg || rsp.ready;

    tis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rd_row    (rd_row)
    );

    tis_node_mem u_mem (
        .clk    (clk),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_data_reg.found;
    assign rsp.word_id     = rsp_data_reg.word_id;
    assign rsp.table_full  = rsp_data_reg.table_full;
    assign rsp.prefix_free = rsp_data_reg.prefix_free;
    assign rsp.nodes_used  = rsp_data_reg.nodes_used;

endmodule

FILE: verif/tb_trie_insert_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trie_insert_search_core
// Self-checking testbench for the trie insert/search core.
// ----------------------------------------------------------------------------
// Letter beats are queued by the stimulus process and driven at the falling
// edge; accepted beats run through an in-bench trie model that predicts each
// word result, and result beats are compared field by field in order. The run
// covers directed corner words, random dictionary traffic and a table fill,
// under four flow-control mixes of idling and stalling.
// ----------------------------------------------------------------------------
module tb_trie_insert_search_core;
    import tis_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_LEN     = 8;
    localparam int PHASE_BEATS = 30;
    localparam int FILL_WORDS  = 34;
    localparam int FILL_LEN    = 30;

    localparam logic [SYMBOL_W-1:0] L_A = 5'd0;
    localparam logic [SYMBOL_W-1:0] L_B = 5'd1;
    localparam logic [SYMBOL_W-1:0] L_C = 5'd2;
    localparam logic [SYMBOL_W-1:0] L_Q = 5'd16;
    localparam logic [SYMBOL_W-1:0] L_R = 5'd17;
    localparam logic [SYMBOL_W-1:0] L_Y = 5'd24;
    localparam logic [SYMBOL_W-1:0] L_Z = 5'd25;

    typedef struct packed {
        logic [3:0]                        len;
        logic [MAX_LEN-1:0][SYMBOL_W-1:0]  ltr;
    } word_t;

    logic clk;
    logic rst_n;

    tis_req_if req_bus();
    tis_rsp_if rsp_bus();

    trie_insert_search_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // trie model state
    node_t              child_of [NODES][ALPHABET];
    logic               tag_set  [NODES];
    logic [ID_BITS-1:0] tag_id   [NODES];
    logic               has_kid  [NODES];
    logic [CNT_W-1:0]   node_count;
    logic [ID_BITS-1:0] next_id;
    node_t              cursor;
    logic               walk_failed;
    logic               prefix_ok;

    item_t   beats_to_send[$];
    result_t word_results_due[$];
    word_t   stored_words[$];

    item_t   drive_beat;
    item_t   taken_beat;
    result_t rsp_beat;
    result_t want;
    result_t predicted;

    int   sender_idle_pct;
    int   rcv_stall_pct;
    int   errors;
    int   idle_cycles;
    int   beats_queued;
    logic req_taken;

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    task automatic clear_trie();
        for (int n = 0; n < NODES; n++)
        begin
            for (int s = 0; s < ALPHABET; s++)
                child_of[n][s] = '0;
            tag_set[n] = 1'b0;
            has_kid[n] = 1'b0;
        end
        node_count  = 1;
        next_id     = '0;
        cursor      = '0;
        walk_failed = 1'b0;
        prefix_ok   = 1'b1;
    endtask

    function automatic bit advance_trie(input item_t beat, output result_t res);
        node_t nxt;
        logic  has_letter;
        res = '0;
        has_letter = !beat.no_symbol && (beat.symbol < ALPHABET);
        if (has_letter && !walk_failed)
        begin
            nxt = child_of[cursor][beat.symbol];
            if (nxt != '0)
                cursor = nxt;
            else if (beat.req_type == REQ_SEARCH)
                walk_failed = 1'b1;
            else if (node_count >= NODES)
                walk_failed = 1'b1;
            else
            begin
                nxt = node_count[NODE_W-1:0];
                node_count = node_count + 1'b1;
                child_of[cursor][beat.symbol] = nxt;
                has_kid[cursor] = 1'b1;
                if (tag_set[cursor])
                    prefix_ok = 1'b0;
                cursor = nxt;
            end
        end
        if (!beat.last)
            return 1'b0;
        if (beat.req_type == REQ_SEARCH)
        begin
            if (!walk_failed && tag_set[cursor])
            begin
                res.found   = 1'b1;
                res.word_id = tag_id[cursor];
            end
        end
        else if (walk_failed)
            res.table_full = 1'b1;
        else
        begin
            tag_id[cursor]  = next_id;
            tag_set[cursor] = 1'b1;
            if (has_kid[cursor])
                prefix_ok = 1'b0;
            res.found   = 1'b1;
            res.word_id = next_id;
            next_id     = next_id + 1'b1;
        end
        res.prefix_free = prefix_ok;
        res.nodes_used  = node_count;
        cursor      = '0;
        walk_failed = 1'b0;
        return 1'b1;
    endfunction

    task automatic push_beat(input logic kind, input logic [SYMBOL_W-1:0] sym,
                             input logic blank, input logic fin);
        item_t beat;
        beat.req_type  = kind;
        beat.symbol    = sym;
        beat.no_symbol = blank;
        beat.last      = fin;
        beats_to_send = {beats_to_send, beat};
        beats_queued++;
    endtask

    // beat without a letter: either flagged, or an out-of-range symbol
    task automatic push_blank(input logic kind, input logic fin);
        if ($urandom_range(1))
            push_beat(kind, SYMBOL_W'($urandom_range(31)), 1'b1, fin);
        else
            push_beat(kind, SYMBOL_W'($urandom_range(ALPHABET, 31)), 1'b0, fin);
    endtask

    function automatic word_t random_word();
        word_t w;
        bit    narrow;
        w = '0;
        w.len = 4'($urandom_range(1, 6));
        narrow = bit'($urandom_range(1));
        for (int i = 0; i < MAX_LEN; i++)
            w.ltr[i] = SYMBOL_W'(narrow ? $urandom_range(3) : $urandom_range(ALPHABET - 1));
        return w;
    endfunction

    task automatic send_word(input logic kind, input word_t w, input bit noisy,
                             input bit mixed);
        bit   blank_end;
        logic k;
        blank_end = (w.len == 0) || (noisy && $urandom_range(3) == 0);
        for (int i = 0; i < w.len; i++)
        begin
            if (noisy && $urandom_range(5) == 0)
                push_blank(mixed ? logic'($urandom_range(1)) : kind, 1'b0);
            k = mixed ? logic'($urandom_range(1)) : kind;
            push_beat(k, w.ltr[i], 1'b0, !blank_end && (i == w.len - 1));
        end
        if (blank_end)
            push_blank(mixed ? logic'($urandom_range(1)) : kind, 1'b1);
    endtask

    task automatic run_random(input int n);
        int    start;
        int    pick;
        word_t w;
        start = beats_queued;
        while (beats_queued - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 35 || stored_words.size() == 0)
            begin
                w = random_word();
                send_word(REQ_INSERT, w, $urandom_range(3) == 0, 1'b0);
                stored_words = {stored_words, w};
            end
            else if (pick < 65)
            begin
                w = stored_words[$urandom_range(stored_words.size() - 1)];
                pick = $urandom_range(9);
                if (pick < 2)
                    w.len = w.len - 1'b1;
                else if (pick < 4 && w.len < MAX_LEN)
                begin
                    w.ltr[w.len[2:0]] = SYMBOL_W'($urandom_range(ALPHABET - 1));
                    w.len = w.len + 1'b1;
                end
                send_word(REQ_SEARCH, w, $urandom_range(7) == 0, 1'b0);
            end
            else if (pick < 75)
            begin
                w = stored_words[$urandom_range(stored_words.size() - 1)];
                send_word(REQ_INSERT, w, $urandom_range(7) == 0, 1'b0);
            end
            else if (pick < 85)
                send_word(REQ_SEARCH, random_word(), 1'b0, 1'b0);
            else
            begin
                w = random_word();
                if ($urandom_range(3) == 0)
                    w.len = 0;
                send_word(logic'($urandom_range(1)), w, 1'b1, 1'b1);
            end
        end
    endtask

    task automatic drain();
        while (beats_to_send.size() != 0 || req_bus.valid || word_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string fname, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_val, act_val);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (!req_bus.valid || req_taken)
        begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                drive_beat = beats_to_send.pop_front();
                req_bus.valid     <= 1'b1;
                req_bus.req_type  <= drive_beat.req_type;
                req_bus.symbol    <= drive_beat.symbol;
                req_bus.no_symbol <= drive_beat.no_symbol;
                req_bus.last      <= drive_beat.last;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        rsp_bus.ready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                rsp_beat = {rsp_bus.found, rsp_bus.word_id, rsp_bus.table_full,
                            rsp_bus.prefix_free, rsp_bus.nodes_used};
                if (word_results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with none expected, expected none, actual %h",
                             $time, rsp_beat);
                end
                else
                begin
                    want = word_results_due.pop_front();
                    check_field("found", 16'(want.found), 16'(rsp_beat.found));
                    check_field("word_id", want.word_id, rsp_beat.word_id);
                    check_field("table_full", 16'(want.table_full), 16'(rsp_beat.table_full));
                    check_field("prefix_free", 16'(want.prefix_free),
                                16'(rsp_beat.prefix_free));
                    check_field("nodes_used", 16'(want.nodes_used), 16'(rsp_beat.nodes_used));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                taken_beat = {req_bus.req_type, req_bus.symbol, req_bus.no_symbol,
                              req_bus.last};
                if (advance_trie(taken_beat, predicted))
                    word_results_due = {word_results_due, predicted};
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** trie_insert_search_core: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = REQ_INSERT;
        req_bus.symbol    = '0;
        req_bus.no_symbol = 1'b0;
        req_bus.last      = 1'b0;
        rsp_bus.ready     = 1'b0;
        sender_idle_pct   = 0;
        rcv_stall_pct     = 0;
        errors            = 0;
        beats_queued      = 0;
        clear_trie();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed words
        push_beat(REQ_INSERT, L_A, 1'b0, 1'b0);
        push_beat(REQ_INSERT, L_B, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_A, 1'b0, 1'b0);
        push_beat(REQ_SEARCH, L_B, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_A, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_A, 1'b0, 1'b0);
        push_beat(REQ_SEARCH, L_B, 1'b0, 1'b0);
        push_beat(REQ_SEARCH, L_C, 1'b0, 1'b1);
        push_beat(REQ_INSERT, L_Z, 1'b0, 1'b0);
        push_beat(REQ_INSERT, 5'd31, 1'b0, 1'b0);
        push_beat(REQ_INSERT, 5'd5, 1'b1, 1'b0);
        push_beat(REQ_INSERT, L_Y, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_Z, 1'b0, 1'b1);
        push_beat(REQ_INSERT, L_A, 1'b0, 1'b0);
        push_beat(REQ_INSERT, L_B, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_A, 1'b0, 1'b0);
        push_beat(REQ_INSERT, L_C, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_Q, 1'b0, 1'b0);
        push_beat(REQ_INSERT, L_R, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, 5'd0, 1'b1, 1'b1);
        push_beat(REQ_INSERT, L_A, 1'b0, 1'b1);
        push_beat(REQ_INSERT, 5'd31, 1'b1, 1'b1);
        push_beat(REQ_SEARCH, 5'd30, 1'b0, 1'b1);
        push_beat(REQ_SEARCH, L_A, 1'b0, 1'b1);

        run_random(PHASE_BEATS);
        drain();

        sender_idle_pct = 77;
        run_random(PHASE_BEATS);
        drain();

        sender_idle_pct = 0;
        rcv_stall_pct   = 77;
        // long random words exhaust the node table
        for (int w = 0; w < FILL_WORDS; w++)
            for (int i = 0; i < FILL_LEN; i++)
                push_beat(REQ_INSERT, SYMBOL_W'($urandom_range(ALPHABET - 1)), 1'b0,
                          i == FILL_LEN - 1);
        run_random(PHASE_BEATS);
        drain();

        sender_idle_pct = 27;
        rcv_stall_pct   = 27;
        run_random(PHASE_BEATS);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && word_results_due.size() == 0)
            $display("** trie_insert_search_core: PASSED **");
        else
            $display("** trie_insert_search_core: FAILED **");
        $finish;
    end

endmodule
